/* design/jarn_pkg.sv */
// Shared types and constants for the joystick recenter and normalize unit.
`default_nettype none
package jarn_pkg;

  localparam int ADC_W     = 12;
  localparam int MODE_W    = 2;
  localparam int SPAN_W    = 24;
  localparam int BAND_W    = 15;
  localparam int GAIN_W    = 17;
  localparam int KICK_W    = 15;
  localparam int LIMIT_W   = 8;
  localparam int OPT_W     = 3;
  localparam int STREAK_W  = 8;
  localparam int NORM_W    = 16;
  localparam int MAG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  // Output beat bit positions.
  localparam int OB_BOUND    = 0;
  localparam int OB_LOST     = 1;
  localparam int OB_FRESH    = 2;
  localparam int OB_NORM_X   = 3;
  localparam int OB_NORM_Y   = 19;
  localparam int OB_PRESSED  = 35;
  localparam int OB_ACTIVITY = 36;

  localparam logic [MAG_W-1:0]    UNIT_Q14   = 15'd16384;
  localparam logic [GAIN_W-1:0]   GAIN_ONE   = 17'd65536;
  localparam logic [STREAK_W-1:0] STREAK_MAX = 8'd255;

  localparam logic [SPAN_W-1:0]  SPAN_RST  = 24'd8192;
  localparam logic [BAND_W-1:0]  BAND_RST  = 15'd4915;
  localparam logic [GAIN_W-1:0]  GAIN_RST  = 17'd1311;
  localparam logic [KICK_W-1:0]  KICK_RST  = 15'd3277;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd5;
  localparam logic [OPT_W-1:0]   OPT_RST   = 3'd0;

  localparam int OPT_SWAP  = 0;
  localparam int OPT_INV_X = 1;
  localparam int OPT_INV_Y = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_BIND   = 2'd1,
    MODE_UNBIND = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPAN    = 3'd0,
    CFG_BAND    = 3'd1,
    CFG_GAIN    = 3'd2,
    CFG_KICK    = 3'd3,
    CFG_LIMIT   = 3'd4,
    CFG_OPTIONS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic bound;
    logic lost;
    logic fresh;
    logic button;
  } ctrl_t;

endpackage
`default_nettype wire

/* design/jarn_axis_lane.sv */
// One axis lane: center subtract, reciprocal scale, band test and center adaptation.
`default_nettype none
module jarn_axis_lane #(
  parameter int SAMPLE_BITS      = 12,
  parameter int CENTER_FRAC_BITS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        step_i,
  input  wire logic                        adapt_i,
  input  wire logic                        load_i,
  input  wire logic [jarn_pkg::ADC_W-1:0]  sample_i,
  input  wire logic [jarn_pkg::SPAN_W-1:0] span_i,
  input  wire logic [jarn_pkg::BAND_W-1:0] band_i,
  input  wire logic [jarn_pkg::GAIN_W-1:0] gain_i,
  output logic      [jarn_pkg::MAG_W-1:0]  mag_o,
  output logic                             neg_o
);

  localparam int CW  = SAMPLE_BITS + CENTER_FRAC_BITS;
  localparam int SU  = (SAMPLE_BITS < jarn_pkg::ADC_W) ? SAMPLE_BITS : jarn_pkg::ADC_W;
  localparam int PW1 = CW + jarn_pkg::SPAN_W;
  localparam int SH1 = CENTER_FRAC_BITS + 10;
  localparam int RW  = PW1 + 1 - SH1;
  localparam int PW2 = CW + jarn_pkg::GAIN_W;
  localparam int SH2 = 16;

  logic [CW-1:0]                  center_q, center_d;
  logic [SAMPLE_BITS-1:0]         samp;
  logic [CW-1:0]                  samp_c;
  logic [CW:0]                    diff, diff_abs;
  logic                           neg;
  logic [CW-1:0]                  mag;
  logic [PW1:0]                   prod1, sum1;
  logic [RW-1:0]                  rmag;
  logic [jarn_pkg::GAIN_W-1:0]    gain_sat;
  logic [PW2:0]                   prod2, sum2;
  logic [CW-1:0]                  step;
  logic                           band_hit;
  logic [jarn_pkg::MAG_W-1:0]     mag_q, mag_d;
  logic                           neg_q;

  assign samp     = SAMPLE_BITS'(sample_i[SU-1:0]);
  assign samp_c   = {samp, {CENTER_FRAC_BITS{1'b0}}};
  assign diff     = {1'b0, samp_c} - {1'b0, center_q};
  assign neg      = diff[CW];
  assign diff_abs = neg ? (~diff + (CW+1)'(1)) : diff;
  assign mag      = diff_abs[CW-1:0];

  assign prod1 = (PW1+1)'(mag) * (PW1+1)'(span_i);
  assign sum1  = prod1 + ((PW1+1)'(1) << (SH1 - 1));
  assign rmag  = sum1[PW1:SH1];

  assign gain_sat = (gain_i > jarn_pkg::GAIN_ONE) ? jarn_pkg::GAIN_ONE : gain_i;
  assign prod2    = (PW2+1)'(mag) * (PW2+1)'(gain_sat);
  assign sum2     = prod2 + ((PW2+1)'(1) << (SH2 - 1));
  assign step     = sum2[SH2 +: CW];

  assign band_hit = rmag < RW'(band_i);

  always_comb begin
    center_d = center_q;
    if (load_i) begin
      center_d = samp_c;
    end else if (adapt_i && band_hit) begin
      center_d = neg ? (center_q - step) : (center_q + step);
    end
  end

  assign mag_d = (rmag > RW'(jarn_pkg::UNIT_Q14)) ? jarn_pkg::UNIT_Q14 : rmag[jarn_pkg::MAG_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CW'(1) << (CW - 1);
    end else begin
      center_q <= center_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mag_q <= mag_d;
      neg_q <= neg;
    end
  end

  assign mag_o = mag_q;
  assign neg_o = neg_q;

endmodule
`default_nettype wire

/* design/jarn_merge.sv */
// Merge stage: swap, invert, activity test, held values and the output register.
`default_nettype none
module jarn_merge (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s1_valid_i,
  input  wire jarn_pkg::ctrl_t                 s1_ctrl_i,
  input  wire logic [jarn_pkg::MAG_W-1:0]      mag_x_i,
  input  wire logic                            neg_x_i,
  input  wire logic [jarn_pkg::MAG_W-1:0]      mag_y_i,
  input  wire logic                            neg_y_i,
  input  wire logic [jarn_pkg::OPT_W-1:0]      options_i,
  input  wire logic [jarn_pkg::KICK_W-1:0]     kick_i,
  input  wire logic                            m_tready_i,
  output logic                                 s1_ready_o,
  output logic                                 m_tvalid_o,
  output logic [jarn_pkg::OUT_DATA_W-1:0]      m_tdata_o
);

  logic                               adv;
  logic                               out_valid_q;
  logic [jarn_pkg::OUT_DATA_W-1:0]    out_data_q, out_data_d;
  logic [jarn_pkg::NORM_W-1:0]        held_x_q, held_x_d, held_y_q, held_y_d;
  logic                               held_btn_q, held_btn_d;
  logic [jarn_pkg::NORM_W-1:0]        val_x, val_y, sw_x, sw_y;
  logic                               neg_sx, neg_sy;
  logic                               activity;

  assign adv        = !out_valid_q || m_tready_i;
  assign s1_ready_o = adv;

  always_comb begin
    neg_sx = neg_x_i ^ options_i[jarn_pkg::OPT_INV_X];
    neg_sy = neg_y_i ^ options_i[jarn_pkg::OPT_INV_Y];
    if (options_i[jarn_pkg::OPT_SWAP]) begin
      neg_sx = neg_y_i ^ options_i[jarn_pkg::OPT_INV_X];
      neg_sy = neg_x_i ^ options_i[jarn_pkg::OPT_INV_Y];
    end
    sw_x  = jarn_pkg::NORM_W'(options_i[jarn_pkg::OPT_SWAP] ? mag_y_i : mag_x_i);
    sw_y  = jarn_pkg::NORM_W'(options_i[jarn_pkg::OPT_SWAP] ? mag_x_i : mag_y_i);
    val_x = neg_sx ? (~sw_x + jarn_pkg::NORM_W'(1)) : sw_x;
    val_y = neg_sy ? (~sw_y + jarn_pkg::NORM_W'(1)) : sw_y;
    activity = s1_ctrl_i.fresh &&
               ((mag_x_i > kick_i) || (mag_y_i > kick_i) || s1_ctrl_i.button);
  end

  always_comb begin
    held_x_d   = held_x_q;
    held_y_d   = held_y_q;
    held_btn_d = held_btn_q;
    if (s1_ctrl_i.fresh) begin
      held_x_d   = val_x;
      held_y_d   = val_y;
      held_btn_d = s1_ctrl_i.button;
    end
    out_data_d = '0;
    out_data_d[jarn_pkg::OB_BOUND]                        = s1_ctrl_i.bound;
    out_data_d[jarn_pkg::OB_LOST]                         = s1_ctrl_i.lost;
    out_data_d[jarn_pkg::OB_FRESH]                        = s1_ctrl_i.fresh;
    out_data_d[jarn_pkg::OB_NORM_X +: jarn_pkg::NORM_W]   = held_x_d;
    out_data_d[jarn_pkg::OB_NORM_Y +: jarn_pkg::NORM_W]   = held_y_d;
    out_data_d[jarn_pkg::OB_PRESSED]                      = held_btn_d;
    out_data_d[jarn_pkg::OB_ACTIVITY]                     = activity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_x_q    <= '0;
      held_y_q    <= '0;
      held_btn_q  <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_i;
      if (s1_valid_i) begin
        held_x_q   <= held_x_d;
        held_y_q   <= held_y_d;
        held_btn_q <= held_btn_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_i) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule
`default_nettype wire

/* design/joystick_adaptive_recenter_normalizer_unit.sv */
// Top level of the two-axis joystick recenter and normalize unit.
//
// channel   dir  handshake               payload
// s_axis    in   s_axis_tvalid/tready    tuser mode; tdata read_ok, adc_x, adc_y, button
// m_axis    out  m_axis_tvalid/tready    tdata bound, lost, fresh, norm_x, norm_y, pressed,
//                                        activity
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One beat in per cycle while the lane stage can advance; each result passes through the lane
// register, then the output register. The per-sample center feedback runs inside the axis
// lanes, which sets the one-beat-per-cycle rate. Reset clears binding, streak, held values
// and restores centers and configuration. A stalled output holds the output register, and
// once the lane stage is full it holds that too and drops s_axis_tready; cfg is always ready.
`default_nettype none
module joystick_adaptive_recenter_normalizer_unit #(
  parameter int SAMPLE_BITS      = 12,
  parameter int CENTER_FRAC_BITS = 8
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // [0] read_ok, [12:1] adc_x, [24:13] adc_y, [25] button
  input  wire logic [jarn_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [1:0] mode
  input  wire logic [jarn_pkg::MODE_W-1:0]         s_axis_tuser_i,
  output logic                                     m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // [0] bound, [1] lost, [2] fresh, [18:3] norm_x, [34:19] norm_y, [35] pressed,
  // [36] activity
  output logic [jarn_pkg::OUT_DATA_W-1:0]          m_axis_tdata_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [jarn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [jarn_pkg::CFG_DAT_W-1:0]      cfg_data_i
);

  logic [jarn_pkg::SPAN_W-1:0]   span_q;
  logic [jarn_pkg::BAND_W-1:0]   band_q;
  logic [jarn_pkg::GAIN_W-1:0]   gain_q;
  logic [jarn_pkg::KICK_W-1:0]   kick_q;
  logic [jarn_pkg::LIMIT_W-1:0]  limit_q;
  logic [jarn_pkg::OPT_W-1:0]    opt_q;

  logic                          bound_q, bound_d;
  logic [jarn_pkg::STREAK_W-1:0] streak_q, streak_d, streak_inc;
  logic                          s1_valid_q;
  jarn_pkg::ctrl_t               s1_ctrl_q, ctrl_d;
  logic                          s1_ready, in_fire, adapt, load;

  logic                          read_ok, button;
  logic [jarn_pkg::ADC_W-1:0]    adc_x, adc_y;
  logic [jarn_pkg::MAG_W-1:0]    mag_x, mag_y;
  logic                          neg_x, neg_y;

  assign read_ok = s_axis_tdata_i[0];
  assign adc_x   = s_axis_tdata_i[1 +: jarn_pkg::ADC_W];
  assign adc_y   = s_axis_tdata_i[1 + jarn_pkg::ADC_W +: jarn_pkg::ADC_W];
  assign button  = s_axis_tdata_i[1 + 2 * jarn_pkg::ADC_W];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q  <= jarn_pkg::SPAN_RST;
      band_q  <= jarn_pkg::BAND_RST;
      gain_q  <= jarn_pkg::GAIN_RST;
      kick_q  <= jarn_pkg::KICK_RST;
      limit_q <= jarn_pkg::LIMIT_RST;
      opt_q   <= jarn_pkg::OPT_RST;
    end else if (cfg_valid_i) begin
      case (jarn_pkg::cfg_idx_e'(cfg_index_i))
        jarn_pkg::CFG_SPAN:    span_q  <= cfg_data_i[jarn_pkg::SPAN_W-1:0];
        jarn_pkg::CFG_BAND:    band_q  <= cfg_data_i[jarn_pkg::BAND_W-1:0];
        jarn_pkg::CFG_GAIN:    gain_q  <= cfg_data_i[jarn_pkg::GAIN_W-1:0];
        jarn_pkg::CFG_KICK:    kick_q  <= cfg_data_i[jarn_pkg::KICK_W-1:0];
        jarn_pkg::CFG_LIMIT:   limit_q <= cfg_data_i[jarn_pkg::LIMIT_W-1:0];
        jarn_pkg::CFG_OPTIONS: opt_q   <= cfg_data_i[jarn_pkg::OPT_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = !s1_valid_q || s1_ready;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign streak_inc = (streak_q == jarn_pkg::STREAK_MAX) ? streak_q
                                                         : streak_q + jarn_pkg::STREAK_W'(1);

  always_comb begin
    bound_d  = bound_q;
    streak_d = streak_q;
    ctrl_d   = '0;
    adapt    = 1'b0;
    load     = 1'b0;
    case (jarn_pkg::mode_e'(s_axis_tuser_i))
      jarn_pkg::MODE_BIND: begin
        bound_d  = 1'b1;
        streak_d = '0;
        load     = 1'b1;
      end
      jarn_pkg::MODE_UNBIND: begin
        bound_d = 1'b0;
      end
      jarn_pkg::MODE_SAMPLE: begin
        if (bound_q) begin
          if (!read_ok) begin
            streak_d = streak_inc;
            if (streak_inc >= limit_q) begin
              bound_d     = 1'b0;
              ctrl_d.lost = 1'b1;
            end
          end else begin
            streak_d      = '0;
            adapt         = 1'b1;
            ctrl_d.fresh  = 1'b1;
            ctrl_d.button = button;
          end
        end
      end
      default: ;
    endcase
    ctrl_d.bound = bound_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bound_q    <= 1'b0;
      streak_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
      if (in_fire) begin
        bound_q  <= bound_d;
        streak_q <= streak_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ctrl_q <= ctrl_d;
    end
  end

  jarn_axis_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CENTER_FRAC_BITS (CENTER_FRAC_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .adapt_i  (in_fire && adapt),
    .load_i   (in_fire && load),
    .sample_i (adc_x),
    .span_i   (span_q),
    .band_i   (band_q),
    .gain_i   (gain_q),
    .mag_o    (mag_x),
    .neg_o    (neg_x)
  );

  jarn_axis_lane #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .CENTER_FRAC_BITS (CENTER_FRAC_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_fire),
    .adapt_i  (in_fire && adapt),
    .load_i   (in_fire && load),
    .sample_i (adc_y),
    .span_i   (span_q),
    .band_i   (band_q),
    .gain_i   (gain_q),
    .mag_o    (mag_y),
    .neg_o    (neg_y)
  );

  jarn_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_ctrl_i  (s1_ctrl_q),
    .mag_x_i    (mag_x),
    .neg_x_i    (neg_x),
    .mag_y_i    (mag_y),
    .neg_y_i    (neg_y),
    .options_i  (opt_q),
    .kick_i     (kick_q),
    .m_tready_i (m_axis_tready_i),
    .s1_ready_o (s1_ready),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
`default_nettype wire

/* design/jarn_checker.sv */
// Port-level checks for the joystick unit and their bind to the top level.
`default_nettype none
module jarn_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            m_axis_tvalid_o,
  input wire logic                            m_axis_tready_i,
  input wire logic [jarn_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  logic                               bound, lost, fresh, activity;
  logic signed [jarn_pkg::NORM_W-1:0] nx, ny;

  assign bound    = m_axis_tdata_o[jarn_pkg::OB_BOUND];
  assign lost     = m_axis_tdata_o[jarn_pkg::OB_LOST];
  assign fresh    = m_axis_tdata_o[jarn_pkg::OB_FRESH];
  assign activity = m_axis_tdata_o[jarn_pkg::OB_ACTIVITY];
  assign nx       = $signed(m_axis_tdata_o[jarn_pkg::OB_NORM_X +: jarn_pkg::NORM_W]);
  assign ny       = $signed(m_axis_tdata_o[jarn_pkg::OB_NORM_Y +: jarn_pkg::NORM_W]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  a_lost_unbound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && lost |-> !bound && !fresh)
    else $error("lost beat still bound or fresh");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (fresh || activity) |-> bound && fresh)
    else $error("activity or fresh without a bound fresh sample");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> nx >= -16'sd16384 && nx <= 16'sd16384 &&
                        ny >= -16'sd16384 && ny <= 16'sd16384)
    else $error("normalized value outside unit range");

endmodule

bind joystick_adaptive_recenter_normalizer_unit jarn_checker u_jarn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
`default_nettype wire
